// ===== hdl/ltsc_pkg.sv =====
// Shared constants and types for the LRU tagged slot cache.
package ltsc_pkg;

  // Store geometry and tag fields.
  localparam int SLOT_COUNT     = 32;
  localparam int TILES_PER_EDGE = 64;
  localparam int MAX_SCALE      = 8;
  localparam int IDX_W          = $clog2(SLOT_COUNT);
  localparam int CNT_W          = $clog2(SLOT_COUNT + 1);
  localparam int RANK_W         = IDX_W;
  localparam int KEY_W          = 31;
  localparam int SCALE_W        = 4;
  localparam int EDGE_W         = 10;

  // Operation codes of a request word.
  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_INSTALL = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_INST,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/ltsc_if.sv =====
// Request and response channel interfaces of the LRU tagged slot cache.
interface ltsc_req_if;
  logic                         valid;
  logic                         ready;
  ltsc_pkg::op_t                opcode;
  logic [ltsc_pkg::KEY_W-1:0]   region_key;
  logic [ltsc_pkg::SCALE_W-1:0] pixel_scale;

  modport source (output valid, opcode, region_key, pixel_scale, input ready);
  modport sink   (input valid, opcode, region_key, pixel_scale, output ready);
endinterface

interface ltsc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [ltsc_pkg::IDX_W-1:0]  slot_index;
  logic [ltsc_pkg::EDGE_W-1:0] edge_pixels;
  logic                        replaced;

  modport source (output valid, hit, slot_index, edge_pixels, replaced, input ready);
  modport sink   (input valid, hit, slot_index, edge_pixels, replaced, output ready);
endinterface

// ===== hdl/lru_tagged_slot_cache.sv =====
// Fully associative tag store of 32 slots with least recently used
// replacement. One request word is taken at a time. A lookup scans the tag
// memory one slot per cycle through a registered tag read, an install scans
// the valid bits and ranks one slot per cycle, and a clear or an unused
// opcode goes straight to the done state. The request side is ready only
// between operations; a finished response waits in an output register while
// the next request is taken. While that register still holds a word the
// receiver has not taken, the block holds in its last cycle and the request
// side stays blocked. Each slot carries a recency rank (0 is the least
// recent) in place of a time stamp, so nothing ever wraps. Keys and scales
// of slots never installed are never compared.
module lru_tagged_slot_cache (
  input logic       clk,
  input logic       rst,
  ltsc_req_if.sink  req,
  ltsc_rsp_if.source rsp
);
  import ltsc_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // Control state.
  state_t                state, state_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  cmp_live, cmp_live_next;
  logic [IDX_W-1:0]      oldest, oldest_next;
  logic [SLOT_COUNT-1:0] valid, valid_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [RANK_W-1:0]     rank [SLOT_COUNT];
  logic [RANK_W-1:0]     rank_next [SLOT_COUNT];

  // Latched request fields.
  logic [KEY_W-1:0]      key_q;
  logic [SCALE_W-1:0]    scale_q;
  logic [SCALE_W-1:0]    scale_clamped;

  // Tag memory and its registered read word.
  logic [KEY_W+SCALE_W-1:0] tag_mem [SLOT_COUNT];
  logic [KEY_W+SCALE_W-1:0] rd_word;
  logic                     mem_we;

  // Commit controls from the sequencer.
  logic             do_clear, do_fill, do_promote;
  logic [IDX_W-1:0] tgt;

  // Pending result and output register.
  logic              res_hit, res_hit_next;
  logic [IDX_W-1:0]  res_slot, res_slot_next;
  logic [EDGE_W-1:0] res_edge, res_edge_next;
  logic              res_repl, res_repl_next;
  logic              out_valid, out_valid_next, out_load;
  logic              out_hit;
  logic [IDX_W-1:0]  out_slot;
  logic [EDGE_W-1:0] out_edge;
  logic              out_repl;
  logic [EDGE_W-1:0] edge_q;

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.slot_index  = out_slot;
  assign rsp.edge_pixels = out_edge;
  assign rsp.replaced    = out_repl;

  // Clamp the requested scale into 1 to MAX_SCALE.
  always_comb begin
    if (req.pixel_scale == '0) begin
      scale_clamped = SCALE_W'(1);
    end else if (req.pixel_scale > SCALE_W'(MAX_SCALE)) begin
      scale_clamped = SCALE_W'(MAX_SCALE);
    end else begin
      scale_clamped = req.pixel_scale;
    end
  end

  assign edge_q = EDGE_W'(TILES_PER_EDGE) * EDGE_W'(scale_q);

  // Sequencer: next state, scan controls and result.
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cmp_live_next = cmp_live;
    oldest_next   = oldest;
    do_clear      = 1'b0;
    do_fill       = 1'b0;
    do_promote    = 1'b0;
    mem_we        = 1'b0;
    tgt           = idx;
    res_hit_next  = res_hit;
    res_slot_next = res_slot;
    res_edge_next = res_edge;
    res_repl_next = res_repl;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        idx_next      = '0;
        cmp_live_next = 1'b0;
        if (req.valid) begin
          res_hit_next  = 1'b0;
          res_slot_next = '0;
          res_edge_next = '0;
          res_repl_next = 1'b0;
          case (req.opcode)
            OP_LOOKUP:  state_next = ST_LOOK;
            OP_INSTALL: state_next = ST_INST;
            OP_CLEAR: begin
              do_clear   = 1'b1;
              state_next = ST_DONE;
            end
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_LOOK: begin
        // Issue a read each cycle and compare the word read the cycle before.
        idx_next      = idx + 1'b1;
        cmp_live_next = 1'b1;
        if (cmp_live) begin
          if (valid[cmp_idx] && rd_word == {key_q, scale_q}) begin
            do_promote    = 1'b1;
            tgt           = cmp_idx;
            res_hit_next  = 1'b1;
            res_slot_next = cmp_idx;
            res_edge_next = edge_q;
            state_next    = ST_DONE;
          end else if (cmp_idx == LAST_IDX) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_INST: begin
        // The lowest free slot wins; with none free the slot of rank zero goes.
        idx_next      = idx + 1'b1;
        res_hit_next  = 1'b1;
        res_edge_next = edge_q;
        if (!valid[idx]) begin
          do_fill       = 1'b1;
          mem_we        = 1'b1;
          tgt           = idx;
          res_slot_next = idx;
          state_next    = ST_DONE;
        end else begin
          if (rank[idx] == '0) begin
            oldest_next = idx;
          end
          if (idx == LAST_IDX) begin
            tgt           = (rank[idx] == '0) ? idx : oldest;
            do_promote    = 1'b1;
            mem_we        = 1'b1;
            res_slot_next = tgt;
            res_repl_next = 1'b1;
            state_next    = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Valid bits, fill count and recency ranks.
  always_comb begin
    valid_next = valid;
    cnt_next   = cnt;
    rank_next  = rank;
    if (do_clear) begin
      valid_next = '0;
      cnt_next   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        rank_next[i] = '0;
      end
    end else if (do_fill) begin
      valid_next[tgt] = 1'b1;
      cnt_next        = cnt + 1'b1;
      rank_next[tgt]  = RANK_W'(cnt);
    end else if (do_promote) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (IDX_W'(i) != tgt && valid[i] && rank[i] > rank[tgt]) begin
          rank_next[i] = rank[i] - 1'b1;
        end
      end
      rank_next[tgt] = RANK_W'(cnt - 1'b1);
    end
  end

  // Output register handshake.
  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      cmp_live  <= 1'b0;
      oldest    <= '0;
      valid     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        rank[i] <= '0;
      end
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      cmp_live  <= cmp_live_next;
      oldest    <= oldest_next;
      valid     <= valid_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
      rank      <= rank_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_idx  <= idx;
    res_hit  <= res_hit_next;
    res_slot <= res_slot_next;
    res_edge <= res_edge_next;
    res_repl <= res_repl_next;
    if (req.valid && req.ready) begin
      key_q   <= req.region_key;
      scale_q <= scale_clamped;
    end
    if (out_load) begin
      out_hit  <= res_hit;
      out_slot <= res_slot;
      out_edge <= res_edge;
      out_repl <= res_repl;
    end
  end

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[tgt] <= {key_q, scale_q};
    end
    rd_word <= tag_mem[idx];
  end

  // The fill count tracks the number of valid slots.
  a_cnt_matches: assert property (@(posedge clk) disable iff (rst)
    cnt == CNT_W'($countones(valid)))
    else $error("fill count differs from valid bits");

  // An eviction happens only with every slot valid.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INST && do_promote) |-> cnt == CNT_W'(SLOT_COUNT))
    else $error("eviction while a slot was free");

  // A delivered word carries an edge size exactly when it reports a hit.
  a_hit_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hit == (out_edge != '0)))
    else $error("hit and edge size disagree");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the LRU tagged slot cache, with its own copy of the tag store.
`timescale 1ns / 100ps

module testbench;
  import ltsc_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = SLOT_COUNT + 8;
  localparam int RANDOM_WORDS  = 1930;

  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    slot_index;
    logic [EDGE_W-1:0]   edge_pixels;
    logic                replaced;
  } tag_result_t;

  logic clk = 1'b0;
  logic rst;

  ltsc_req_if req_ch ();
  ltsc_rsp_if rsp_ch ();

  lru_tagged_slot_cache i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the tag store.
  logic               slot_valid [SLOT_COUNT];
  logic [KEY_W-1:0]   slot_key   [SLOT_COUNT];
  logic [SCALE_W-1:0] slot_scale [SCALE_W > 0 ? SLOT_COUNT : 1];
  int                 slot_rank  [SLOT_COUNT];

  tag_result_t responses_due[$];
  int          mismatch_count = 0;
  bit          steady         = 1'b0;
  bit          hold_pending   = 1'b0;

  always #2 clk = ~clk;

  // Make a valid slot the most recent one, closing the gap it leaves behind.
  function automatic void promote_slot(int s, int live);
    int old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i != s && slot_valid[i] && slot_rank[i] > old_rank) slot_rank[i]--;
    end
    slot_rank[s] = live - 1;
  endfunction

  // Apply one request to the shadow store and return the response it must produce.
  function automatic tag_result_t predict_tag_store(op_t op, logic [KEY_W-1:0] key,
                                                    logic [SCALE_W-1:0] raw_scale);
    tag_result_t res;
    int          scale;
    int          live;
    int          victim;
    int          oldest;
    res    = '0;
    scale  = (raw_scale == 0) ? 1 : (raw_scale > MAX_SCALE) ? MAX_SCALE : int'(raw_scale);
    live   = 0;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < SLOT_COUNT; i++) if (slot_valid[i]) live++;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (victim < 0 && slot_valid[i] && slot_key[i] == key && slot_scale[i] == scale)
            victim = i;
        end
        if (victim >= 0) begin
          promote_slot(victim, live);
          res.hit         = 1'b1;
          res.slot_index  = IDX_W'(victim);
          res.edge_pixels = EDGE_W'(TILES_PER_EDGE * scale);
        end
      end
      OP_INSTALL: begin
        // Lowest free slot first; with none free, the least recent one.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (victim < 0) begin
            if (!slot_valid[i]) victim = i;
            else if (slot_rank[i] < slot_rank[oldest]) oldest = i;
          end
        end
        if (victim >= 0) begin
          slot_rank[victim]  = live;
          slot_valid[victim] = 1'b1;
        end else begin
          victim       = oldest;
          res.replaced = 1'b1;
          promote_slot(victim, live);
        end
        slot_key[victim]   = key;
        slot_scale[victim] = SCALE_W'(scale);
        res.hit            = 1'b1;
        res.slot_index     = IDX_W'(victim);
        res.edge_pixels    = EDGE_W'(TILES_PER_EDGE * scale);
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slot_valid[i] = 1'b0;
          slot_rank[i]  = 0;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Offer one request word, wait for it to be taken and record its response.
  task automatic issue_request(op_t op, logic [KEY_W-1:0] key, logic [SCALE_W-1:0] scale);
    while (!steady && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.region_key  <= key;
    req_ch.pixel_scale <= scale;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    responses_due.push_back(predict_tag_store(op, key, scale));
  endtask

  // Stop offering words until every outstanding response is back.
  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    while (responses_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Lookups on an empty store must all miss.
  task automatic test_empty_store();
    issue_request(OP_LOOKUP, '0, '0);
    issue_request(OP_LOOKUP, 31'h7FFF_FFFF, 4'hF);
  endtask

  // Installs with extreme keys and clamped scales, then hits and misses on them.
  task automatic test_install_and_lookup();
    issue_request(OP_INSTALL, '0, 4'd0);
    issue_request(OP_INSTALL, 31'h7FFF_FFFF, 4'd15);
    issue_request(OP_INSTALL, 31'h2AAA_AAAA, 4'd8);
    issue_request(OP_INSTALL, 31'h5555_5555, 4'd5);
    issue_request(OP_LOOKUP, '0, 4'd1);
    issue_request(OP_LOOKUP, 31'h7FFF_FFFF, 4'd9);
    issue_request(OP_LOOKUP, 31'h7FFF_FFFF, 4'd7);
    issue_request(OP_LOOKUP, 31'h5555_5555, 4'd5);
    issue_request(OP_LOOKUP, 31'h0000_0001, 4'd1);
  endtask

  // A second copy of a stored tag; lookups still report the lower slot.
  task automatic test_duplicate_install();
    issue_request(OP_INSTALL, 31'h5555_5555, 4'd5);
    issue_request(OP_LOOKUP, 31'h5555_5555, 4'd5);
  endtask

  // The unused opcode changes nothing and answers with all fields zero.
  task automatic test_unused_opcode();
    issue_request(OP_NOP, 31'h7FFF_FFFF, 4'hF);
    issue_request(OP_LOOKUP, '0, 4'd1);
  endtask

  // A clear empties the store, so the next install lands in slot zero.
  task automatic test_clear();
    issue_request(OP_CLEAR, 31'h7FFF_FFFF, 4'hF);
    issue_request(OP_LOOKUP, '0, 4'd1);
    issue_request(OP_INSTALL, 31'h0000_1234, 4'd3);
  endtask

  // The receiver holds off while words keep coming, so the input side stalls.
  task automatic test_backpressure();
    wait_for_responses();
    hold_pending = 1'b1;
    for (int n = 0; n < 12; n++) begin
      issue_request(($urandom_range(1) == 0) ? OP_INSTALL : OP_LOOKUP,
                    KEY_W'($urandom_range(3)), SCALE_W'($urandom_range(15)));
    end
    wait_for_responses();
  endtask

  // Mostly installs and lookups of recently stored tags, with rare clears and
  // stray words, so the store fills up and eviction runs for long stretches.
  task automatic test_random_traffic(int count);
    logic [KEY_W-1:0]   key_pool[16];
    logic [KEY_W-1:0]   seen_key[$];
    logic [SCALE_W-1:0] seen_scale[$];
    logic [KEY_W-1:0]   key;
    logic [SCALE_W-1:0] scale;
    int                 pick;
    int                 roll;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      steady = (n >= 700 && n < 1000);
      if (n % 300 == 299) wait_for_responses();
      roll = $urandom_range(999);
      if (roll < 5) begin
        issue_request(OP_CLEAR, KEY_W'($urandom), SCALE_W'($urandom));
      end else if (roll < 30) begin
        issue_request(OP_NOP, KEY_W'($urandom), SCALE_W'($urandom));
      end else if (roll < 400) begin
        key   = ($urandom_range(9) < 8) ? key_pool[$urandom_range(15)] : KEY_W'($urandom);
        scale = SCALE_W'($urandom_range(15));
        issue_request(OP_INSTALL, key, scale);
        seen_key.push_back(key);
        seen_scale.push_back(scale);
        if (seen_key.size() > 64) begin
          void'(seen_key.pop_front());
          void'(seen_scale.pop_front());
        end
      end else if (seen_key.size() != 0 && $urandom_range(3) != 0) begin
        // Recently installed tag, often asked for with another raw scale that
        // clamps to the same value.
        pick  = $urandom_range(seen_key.size() - 1);
        key   = seen_key[pick];
        scale = seen_scale[pick];
        if (scale <= 1) scale = SCALE_W'($urandom_range(1));
        else if (scale >= MAX_SCALE) scale = SCALE_W'($urandom_range(15, MAX_SCALE));
        issue_request(OP_LOOKUP, key, scale);
      end else begin
        issue_request(OP_LOOKUP, key_pool[$urandom_range(15)], SCALE_W'($urandom_range(15)));
      end
    end
    steady = 1'b0;
  endtask

  // Response side: random stalls, plus one long hold-off on request.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        rsp_ch.ready <= 1'b0;
        hold_pending = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 8);
    end
  end

  // Compare every accepted response word with the oldest one due.
  always @(posedge clk) begin
    tag_result_t want;
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (responses_due.size() == 0) begin
        $error("response word with none due: hit %0d slot %0d edge %0d replaced %0d",
               rsp_ch.hit, rsp_ch.slot_index, rsp_ch.edge_pixels, rsp_ch.replaced);
        mismatch_count++;
      end else begin
        want = responses_due.pop_front();
        check_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
        check_field("slot_index", 32'(want.slot_index), 32'(rsp_ch.slot_index));
        check_field("edge_pixels", 32'(want.edge_pixels), 32'(rsp_ch.edge_pixels));
        check_field("replaced", 32'(want.replaced), 32'(rsp_ch.replaced));
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || rst === 1'b1)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_scale[i] = '0;
      slot_rank[i]  = 0;
    end
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= OP_LOOKUP;
    req_ch.region_key  <= '0;
    req_ch.pixel_scale <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_install_and_lookup();
    test_duplicate_install();
    test_unused_opcode();
    test_clear();
    test_backpressure();
    test_random_traffic(RANDOM_WORDS);

    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
